// ===== src/wss_pkg.sv =====
// types, constants and step functions shared by the washer step sequencer
package wss_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_WASH_PASSES = 2'd0;
   localparam logic [1:0] CSR_LEFT_DUTY   = 2'd1;
   localparam logic [1:0] CSR_RIGHT_DUTY  = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;

   localparam logic [6:0] WASH_PASSES_RST = 7'd3;
   localparam logic [6:0] LEFT_DUTY_RST   = 7'd80;
   localparam logic [6:0] RIGHT_DUTY_RST  = 7'd20;

   // main step bit positions
   localparam int MS_IDLE  = 0;
   localparam int MS_FILL  = 1;
   localparam int MS_HEAT  = 2;
   localparam int MS_WASH  = 3;
   localparam int MS_DRAIN = 4;
   localparam int MAIN_STEPS = 5;

   // wash step bit positions
   localparam int WS_IDLE   = 0;
   localparam int WS_LEFT   = 1;
   localparam int WS_PAUSE1 = 2;
   localparam int WS_RIGHT  = 3;
   localparam int WS_PAUSE2 = 4;
   localparam int WS_CHECK  = 5;
   localparam int WS_SPIN   = 6;
   localparam int WS_DONE   = 7;
   localparam int WASH_STEPS = 8;

   localparam int SETTLE_ROUNDS = 8;

   localparam logic [1:0] PERIOD_NONE   = 2'd0;
   localparam logic [1:0] PERIOD_SHORT  = 2'd1;
   localparam logic [1:0] PERIOD_MEDIUM = 2'd2;
   localparam logic [1:0] PERIOD_LONG   = 2'd3;

   localparam logic [9:0] SPIN_COMPARE = 10'd499;
   localparam logic [9:0] COMPARE_MAX  = 10'd999;

   typedef struct packed {
      logic [6:0] wash_passes;
      logic [6:0] left_duty;
      logic [6:0] right_duty;
   } cfg_type;

   typedef struct packed {
      logic start_pressed;
      logic stop_pressed;
      logic tank_full;
      logic water_hot;
      logic tank_empty;
      logic period_tick;
   } req_type;

   typedef struct packed {
      logic [3:0] wash_step;
      logic [2:0] main_step;
      logic       wash_finished;
      logic [1:0] period_code;
      logic       spin_fast;
      logic       motor_running;
      logic [9:0] motor_compare;
      logic       pump_on;
      logic       heater_on;
      logic       fill_valve;
      logic       door_lock;
   } rsp_type;

   typedef struct packed {
      logic [WASH_STEPS-1:0] wash;
      logic [7:0]            pass_count;
      logic                  passes_done;
      logic                  done_latch;
   } wash_state_type;

   function automatic logic [MAIN_STEPS-1:0] main_round(
      input logic [MAIN_STEPS-1:0] m,
      input logic start, input logic stop, input logic full,
      input logic hot, input logic empty, input logic latch);
      logic [MAIN_STEPS-1:0] set;
      logic [MAIN_STEPS-1:0] clr;
      set = '0;
      clr = '0;
      if (m == '0 || (m[MS_DRAIN] && empty)) set[MS_IDLE] = 1'b1;
      if (m[MS_IDLE] && start) begin
         set[MS_FILL] = 1'b1;
         clr[MS_IDLE] = 1'b1;
      end
      if (m[MS_FILL] && full) begin
         set[MS_HEAT] = 1'b1;
         clr[MS_FILL] = 1'b1;
      end
      if (m[MS_HEAT] && hot) begin
         set[MS_WASH] = 1'b1;
         clr[MS_HEAT] = 1'b1;
      end
      if (m[MS_WASH] && (stop || latch)) begin
         set[MS_DRAIN] = 1'b1;
         clr[MS_WASH]  = 1'b1;
      end
      if (m[MS_DRAIN] && empty) clr[MS_DRAIN] = 1'b1;
      return set | (m & ~clr);
   endfunction

   function automatic wash_state_type wash_round(
      input wash_state_type s, input logic men, input logic t,
      input logic stop, input logic empty, input logic [6:0] wp);
      logic [WASH_STEPS-1:0] w;
      logic [WASH_STEPS-1:0] set;
      logic [WASH_STEPS-1:0] clr;
      wash_state_type        n;
      w   = s.wash;
      set = '0;
      clr = '0;
      n   = s;
      if (w == '0) set[WS_IDLE] = 1'b1;
      if ((w[WS_IDLE] && men) || (w[WS_CHECK] && !s.passes_done)) set[WS_LEFT] = 1'b1;
      if (w[WS_IDLE] && men) clr[WS_IDLE] = 1'b1;
      for (int k = WS_LEFT; k <= WS_PAUSE2; k++) begin
         if (w[k] && t) set[k+1] = 1'b1;
      end
      if (w[WS_CHECK] && t && s.passes_done) set[WS_SPIN] = 1'b1;
      if (w[WS_SPIN] && t) set[WS_DONE] = 1'b1;
      for (int k = WS_LEFT; k <= WS_SPIN; k++) begin
         if (k != WS_CHECK && w[k] && (t || stop)) clr[k] = 1'b1;
      end
      if (w[WS_CHECK] && ((t && s.passes_done) || stop || !s.passes_done))
         clr[WS_CHECK] = 1'b1;
      if (w[WS_DONE] && (empty || stop)) clr[WS_DONE] = 1'b1;
      n.wash = set | (w & ~clr);
      // pass count moves on entry to the right turn
      if (set[WS_RIGHT] && (n.pass_count <= {1'b0, wp})) begin
         n.pass_count  = n.pass_count + 8'd1;
         n.passes_done = 1'b0;
      end
      if (n.pass_count > {1'b0, wp}) begin
         n.pass_count  = 8'd1;
         n.passes_done = 1'b1;
      end
      if (n.wash[WS_DONE]) n.done_latch = 1'b1;
      return n;
   endfunction

   function automatic logic [9:0] compare_of(input logic [6:0] duty);
      logic [10:0] v;
      logic [10:0] m1;
      v  = {1'b0, duty, 3'b000} + {3'b000, duty, 1'b0};
      m1 = v - 11'd1;
      if (v == '0) return '0;
      if (m1 > {1'b0, COMPARE_MAX}) return COMPARE_MAX;
      return m1[9:0];
   endfunction

   function automatic logic [2:0] lowest_main(input logic [MAIN_STEPS-1:0] v);
      logic [2:0] idx;
      idx = 3'(MAIN_STEPS);
      for (int k = MAIN_STEPS - 1; k >= 0; k--) begin
         if (v[k]) idx = 3'(k);
      end
      return idx;
   endfunction

   function automatic logic [3:0] lowest_wash(input logic [WASH_STEPS-1:0] v);
      logic [3:0] idx;
      idx = 4'(WASH_STEPS);
      for (int k = WASH_STEPS - 1; k >= 0; k--) begin
         if (v[k]) idx = 4'(k);
      end
      return idx;
   endfunction

endpackage

// ===== src/wss_cfg_regs.sv =====
// configuration registers of the washer step sequencer
module wss_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [wss_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wss_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output wss_pkg::cfg_type                    cfg
);

   wss_pkg::cfg_type cfg_ff;
   wss_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            wss_pkg::CSR_WASH_PASSES: cfg_in.wash_passes = csr_wdata;
            wss_pkg::CSR_LEFT_DUTY:   cfg_in.left_duty   = csr_wdata;
            wss_pkg::CSR_RIGHT_DUTY:  cfg_in.right_duty  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wash_passes <= wss_pkg::WASH_PASSES_RST;
         cfg_ff.left_duty   <= wss_pkg::LEFT_DUTY_RST;
         cfg_ff.right_duty  <= wss_pkg::RIGHT_DUTY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/wss_step_core.sv =====
// step state and settling logic: main machine, wash rounds, result decode
module wss_step_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  wss_pkg::req_type req,
   input  wss_pkg::cfg_type cfg,
   output wss_pkg::rsp_type rsp
);

   logic [wss_pkg::MAIN_STEPS-1:0] main_ff;
   logic [wss_pkg::MAIN_STEPS-1:0] main_in;
   wss_pkg::wash_state_type        wash_ff;
   wss_pkg::wash_state_type        wash_in;

   wss_pkg::wash_state_type        cur;
   wss_pkg::wash_state_type        nxt;
   logic                           running;
   logic                           latch0;
   logic [9:0]                     cmp;
   logic [1:0]                     code;

   always_comb begin
      cur     = wash_ff;
      running = 1'b1;
      nxt     = wash_ff;
      // stop clears the wash steps, drain clears the done flag, before stepping
      if (req.stop_pressed) cur.wash = '0;
      latch0 = req.tank_empty ? 1'b0 : wash_ff.done_latch;
      cur.done_latch = latch0;
      main_in = wss_pkg::main_round(main_ff, req.start_pressed, req.stop_pressed,
                                    req.tank_full, req.water_hot, req.tank_empty,
                                    latch0);
      // settle zero-duration wash transitions, tick only in the first round
      for (int r = 0; r < wss_pkg::SETTLE_ROUNDS; r++) begin
         if (running) begin
            nxt = wss_pkg::wash_round(cur, main_in[wss_pkg::MS_WASH],
                                      (r == 0) ? req.period_tick : 1'b0,
                                      req.stop_pressed, req.tank_empty,
                                      cfg.wash_passes);
            if (nxt.wash == cur.wash && nxt.passes_done == cur.passes_done)
               running = 1'b0;
            cur = nxt;
         end
      end
      wash_in = cur;
   end

   always_comb begin
      if (wash_in.wash[wss_pkg::WS_RIGHT])
         cmp = wss_pkg::compare_of(cfg.right_duty);
      else if (wash_in.wash[wss_pkg::WS_SPIN])
         cmp = wss_pkg::SPIN_COMPARE;
      else if (wash_in.wash[wss_pkg::WS_LEFT])
         cmp = wss_pkg::compare_of(cfg.left_duty);
      else
         cmp = '0;

      if (wash_in.wash[wss_pkg::WS_PAUSE1] || wash_in.wash[wss_pkg::WS_PAUSE2] ||
          (wash_in.wash[wss_pkg::WS_CHECK] && wash_in.passes_done))
         code = wss_pkg::PERIOD_SHORT;
      else if (wash_in.wash[wss_pkg::WS_LEFT] || wash_in.wash[wss_pkg::WS_RIGHT])
         code = wss_pkg::PERIOD_MEDIUM;
      else if (wash_in.wash[wss_pkg::WS_SPIN])
         code = wss_pkg::PERIOD_LONG;
      else
         code = wss_pkg::PERIOD_NONE;

      rsp.door_lock     = |main_in[wss_pkg::MS_DRAIN:wss_pkg::MS_FILL];
      rsp.fill_valve    = main_in[wss_pkg::MS_FILL];
      rsp.heater_on     = main_in[wss_pkg::MS_HEAT];
      rsp.pump_on       = main_in[wss_pkg::MS_DRAIN];
      rsp.motor_compare = cmp;
      rsp.motor_running = |wash_in.wash[wss_pkg::WS_SPIN:wss_pkg::WS_LEFT];
      rsp.spin_fast     = (code == wss_pkg::PERIOD_LONG);
      rsp.period_code   = code;
      rsp.wash_finished = wash_in.done_latch;
      rsp.main_step     = wss_pkg::lowest_main(main_in);
      rsp.wash_step     = wss_pkg::lowest_wash(wash_in.wash);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff             <= '0;
         wash_ff.wash        <= '0;
         wash_ff.pass_count  <= 8'd1;
         wash_ff.passes_done <= 1'b0;
         wash_ff.done_latch  <= 1'b0;
      end else if (step_en) begin
         main_ff <= main_in;
         wash_ff <= wash_in;
      end
   end

endmodule

// ===== src/washer_step_sequencer_unit.sv =====
// top level of the washer step sequencer: input register, step core, result register
// a beat waits in the input register, and its result is registered in the result register as it moves on
// throughput: one beat per cycle while results are taken, the input register refills while its beat moves on
// the step core settles up to eight wash rounds between the two registers
// reset (synchronous, active high): all steps inactive, pass count one, flags clear,
// wash_passes 3, left_duty 80, right_duty 20, both pipeline registers empty
module washer_step_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_pressed, stop_pressed, tank_full, water_hot, tank_empty, period_tick, 2'b0
   input  logic [wss_pkg::REQ_DATA_W-1:0]      req_tdata,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // door_lock, fill_valve, heater_on, pump_on, motor_compare[9:0], motor_running,
   // spin_fast, period_code[1:0], wash_finished, main_step[2:0], wash_step[3:0], 6'b0
   output logic [wss_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [wss_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wss_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   wss_pkg::cfg_type cfg;
   wss_pkg::req_type req_ff;
   wss_pkg::req_type req_in;
   logic             req_valid_ff;
   logic             req_valid_in;
   wss_pkg::rsp_type rsp_ff;
   wss_pkg::rsp_type rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             advance;
   logic             req_take;

   wss_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // the held beat moves into the result register when that slot is free or draining
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   // input register takes a new beat when empty or emptying this cycle
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // unpack the request beat, first field in bit 0
   always_comb begin
      req_in.start_pressed = req_tdata[0];
      req_in.stop_pressed  = req_tdata[1];
      req_in.tank_full     = req_tdata[2];
      req_in.water_hot     = req_tdata[3];
      req_in.tank_empty    = req_tdata[4];
      req_in.period_tick   = req_tdata[5];
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take)     req_valid_in = 1'b1;
      else if (advance) req_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // state advances exactly once per beat, when it leaves the input register
   wss_step_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_in;
      if (advance)  rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000,
                        rsp_ff.wash_step,
                        rsp_ff.main_step,
                        rsp_ff.wash_finished,
                        rsp_ff.period_code,
                        rsp_ff.spin_fast,
                        rsp_ff.motor_running,
                        rsp_ff.motor_compare,
                        rsp_ff.pump_on,
                        rsp_ff.heater_on,
                        rsp_ff.fill_valve,
                        rsp_ff.door_lock};

endmodule

// ===== src/wss_checker.sv =====
// port-level checks for the washer step sequencer, bound to the top level
module wss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [wss_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   // both registers come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result beat changed while stalled");

   // fast spin base goes with the long period code only
   a_spin_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15] == (rsp_tdata[17:16] == wss_pkg::PERIOD_LONG)))
      else $error("spin_fast and period_code disagree");

   // a nonzero compare value only while the motor runs
   a_motor_cmp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[13:4] != 10'd0)) |-> rsp_tdata[14])
      else $error("motor compare set with motor stopped");

endmodule

bind washer_step_sequencer_unit wss_checker u_wss_checker (.*);

// ===== tb/washer_step_sequencer_checker.sv =====
// washer step sequencer checker: follows the handshakes, models the steps and compares results
`timescale 1ns / 100ps
module washer_step_sequencer_checker
   import wss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   logic [CSR_DATA_W-1:0] passes_cfg;
   logic [CSR_DATA_W-1:0] left_duty_cfg;
   logic [CSR_DATA_W-1:0] right_duty_cfg;
   logic [MAIN_STEPS-1:0] main_now;
   logic [WASH_STEPS-1:0] wash_now;
   logic [7:0]            pass_count;
   logic                  passes_done;
   logic                  done_latch;
   rsp_type               awaited_outputs[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic [9:0] duty_compare(input logic [CSR_DATA_W-1:0] duty);
      int v;
      v = int'(duty) * 10;
      if (v == 0) return '0;
      v = v - 1;
      if (v > int'(COMPARE_MAX)) return COMPARE_MAX;
      return 10'(v);
   endfunction

   // advances the modeled machines by one beat and returns the outputs it should give
   function automatic rsp_type step_washer(input logic [5:0] lv);
      logic                  start;
      logic                  stop;
      logic                  full;
      logic                  hot;
      logic                  empty;
      logic                  tick;
      logic                  t;
      logic                  pd_old;
      logic [MAIN_STEPS-1:0] m;
      logic [MAIN_STEPS-1:0] mset;
      logic [MAIN_STEPS-1:0] mclr;
      logic [WASH_STEPS-1:0] w;
      logic [WASH_STEPS-1:0] wset;
      logic [WASH_STEPS-1:0] wclr;
      rsp_type               res;
      {tick, empty, hot, full, stop, start} = lv;

      // stop and the drain sensor act before either machine moves
      if (stop) wash_now = '0;
      if (empty) done_latch = 1'b0;

      m    = main_now;
      mset = '0;
      mclr = '0;
      if (m == '0 || (m[MS_DRAIN] && empty)) mset[MS_IDLE] = 1'b1;
      if (m[MS_IDLE] && start) begin
         mset[MS_FILL] = 1'b1;
         mclr[MS_IDLE] = 1'b1;
      end
      if (m[MS_FILL] && full) begin
         mset[MS_HEAT] = 1'b1;
         mclr[MS_FILL] = 1'b1;
      end
      if (m[MS_HEAT] && hot) begin
         mset[MS_WASH] = 1'b1;
         mclr[MS_HEAT] = 1'b1;
      end
      if (m[MS_WASH] && (stop || done_latch)) begin
         mset[MS_DRAIN] = 1'b1;
         mclr[MS_WASH]  = 1'b1;
      end
      if (m[MS_DRAIN] && empty) mclr[MS_DRAIN] = 1'b1;
      main_now = mset | (m & ~mclr);

      // wash sequence settles in rounds, the tick only counts in the first
      for (int r = 0; r < SETTLE_ROUNDS; r++) begin
         w      = wash_now;
         pd_old = passes_done;
         t      = (r == 0) && tick;
         wset   = '0;
         wclr   = '0;
         if (w == '0) wset[WS_IDLE] = 1'b1;
         if ((w[WS_IDLE] && main_now[MS_WASH]) || (w[WS_CHECK] && !passes_done))
            wset[WS_LEFT] = 1'b1;
         if (w[WS_IDLE] && main_now[MS_WASH]) wclr[WS_IDLE] = 1'b1;
         if (t) begin
            for (int k = WS_LEFT; k <= WS_PAUSE2; k++) if (w[k]) wset[k+1] = 1'b1;
            if (w[WS_CHECK] && passes_done) wset[WS_SPIN] = 1'b1;
            if (w[WS_SPIN]) wset[WS_DONE] = 1'b1;
         end
         if (t || stop) begin
            for (int k = WS_LEFT; k <= WS_SPIN; k++) if (k != WS_CHECK && w[k]) wclr[k] = 1'b1;
         end
         if (w[WS_CHECK] && ((t && passes_done) || stop || !passes_done)) wclr[WS_CHECK] = 1'b1;
         if (w[WS_DONE] && (empty || stop)) wclr[WS_DONE] = 1'b1;
         wash_now = wset | (w & ~wclr);
         if (wset[WS_RIGHT] && pass_count <= {1'b0, passes_cfg}) begin
            pass_count  = pass_count + 8'd1;
            passes_done = 1'b0;
         end
         // a count past the setting wraps, so a lowered setting saturates
         if (pass_count > {1'b0, passes_cfg}) begin
            pass_count  = 8'd1;
            passes_done = 1'b1;
         end
         if (wash_now[WS_DONE]) done_latch = 1'b1;
         if (wash_now == w && passes_done == pd_old) break;
      end

      res            = '0;
      res.door_lock  = |main_now[MS_DRAIN:MS_FILL];
      res.fill_valve = main_now[MS_FILL];
      res.heater_on  = main_now[MS_HEAT];
      res.pump_on    = main_now[MS_DRAIN];
      if (wash_now[WS_RIGHT])     res.motor_compare = duty_compare(right_duty_cfg);
      else if (wash_now[WS_SPIN]) res.motor_compare = SPIN_COMPARE;
      else if (wash_now[WS_LEFT]) res.motor_compare = duty_compare(left_duty_cfg);
      res.motor_running = |wash_now[WS_SPIN:WS_LEFT];
      if (wash_now[WS_PAUSE1] || wash_now[WS_PAUSE2] || (wash_now[WS_CHECK] && passes_done))
         res.period_code = PERIOD_SHORT;
      else if (wash_now[WS_LEFT] || wash_now[WS_RIGHT])
         res.period_code = PERIOD_MEDIUM;
      else if (wash_now[WS_SPIN])
         res.period_code = PERIOD_LONG;
      else
         res.period_code = PERIOD_NONE;
      res.spin_fast     = (res.period_code == PERIOD_LONG);
      res.wash_finished = done_latch;
      res.main_step     = 3'(MAIN_STEPS);
      for (int k = MAIN_STEPS - 1; k >= 0; k--) if (main_now[k]) res.main_step = 3'(k);
      res.wash_step = 4'(WASH_STEPS);
      for (int k = WASH_STEPS - 1; k >= 0; k--) if (wash_now[k]) res.wash_step = 4'(k);
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         passes_cfg     = WASH_PASSES_RST;
         left_duty_cfg  = LEFT_DUTY_RST;
         right_duty_cfg = RIGHT_DUTY_RST;
         main_now       = '0;
         wash_now       = '0;
         pass_count     = 8'd1;
         passes_done    = 1'b0;
         done_latch     = 1'b0;
         awaited_outputs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (awaited_outputs.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with nothing expected, actual %h", $time, rsp_tdata);
            end else begin
               want = awaited_outputs.pop_front();
               check_field("door_lock", want.door_lock, got.door_lock);
               check_field("fill_valve", want.fill_valve, got.fill_valve);
               check_field("heater_on", want.heater_on, got.heater_on);
               check_field("pump_on", want.pump_on, got.pump_on);
               check_field("motor_compare", want.motor_compare, got.motor_compare);
               check_field("motor_running", want.motor_running, got.motor_running);
               check_field("spin_fast", want.spin_fast, got.spin_fast);
               check_field("period_code", want.period_code, got.period_code);
               check_field("wash_finished", want.wash_finished, got.wash_finished);
               check_field("main_step", want.main_step, got.main_step);
               check_field("wash_step", want.wash_step, got.wash_step);
               check_field("pad bits", 0, rsp_tdata[RSP_DATA_W-1:$bits(rsp_type)]);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WASH_PASSES: passes_cfg     = csr_wdata;
               CSR_LEFT_DUTY:   left_duty_cfg  = csr_wdata;
               CSR_RIGHT_DUTY:  right_duty_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) awaited_outputs.push_back(step_washer(req_tdata[5:0]));
      end
      pending = awaited_outputs.size();
   end

endmodule

// ===== tb/washer_step_sequencer_unit_test.sv =====
// washer step sequencer testbench top: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 100ps
module washer_step_sequencer_unit_test;
   import wss_pkg::*;

   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int LONG_HOLD       = 300;
   // worst case is far below this: ~850 beats with long gaps on both sides
   localparam int CYCLE_LIMIT     = 400000;

   // request beat level bits, lowest first as packed in req_tdata
   localparam logic [5:0] LV_START = 6'h01;
   localparam logic [5:0] LV_STOP  = 6'h02;
   localparam logic [5:0] LV_FULL  = 6'h04;
   localparam logic [5:0] LV_HOT   = 6'h08;
   localparam logic [5:0] LV_EMPTY = 6'h10;
   localparam logic [5:0] LV_TICK  = 6'h20;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   int                     fail_count;
   int                     pending;
   int                     cycles     = 0;
   // handshake between the stimulus and the receiver process
   bit                     hold_due   = 1'b0;
   bit                     tx_calm    = 1'b0;
   bit                     rx_calm    = 1'b0;

   // opening beats at reset settings: all-zero, all-ones, then a run cut short by stop
   logic [5:0] opening_beats [0:8] = '{
      6'h00, 6'h3F, LV_START, LV_FULL, LV_HOT, LV_TICK, LV_TICK,
      LV_STOP | LV_TICK, LV_EMPTY
   };
   // a full single-pass wash with a zero pass count, saturated left and zero right duty
   logic [5:0] full_wash_beats [0:11] = '{
      LV_START, LV_FULL, LV_HOT | LV_TICK, LV_TICK, LV_TICK, LV_TICK, LV_TICK,
      LV_TICK, LV_EMPTY, LV_TICK, 6'h00, LV_EMPTY | LV_START
   };

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   washer_step_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   washer_step_sequencer_checker check_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // duty extremes in turn, with a random one every fourth setting
   function automatic logic [CSR_DATA_W-1:0] duty_pick(input int sel);
      case (sel % 4)
         0:       return 7'd0;
         1:       return 7'd100;
         2:       return 7'd127;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // offer one beat and hold it until taken, then idle for gap cycles
   task automatic send_beat(input logic [5:0] lv, input int gap);
      req_tdata  <= {2'b00, lv};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // block is idle here: all three registers written on consecutive edges
   task automatic load_settings(input logic [CSR_DATA_W-1:0] passes,
                                input logic [CSR_DATA_W-1:0] left,
                                input logic [CSR_DATA_W-1:0] right);
      logic [CSR_INDEX_W-1:0] idx [0:2];
      logic [CSR_DATA_W-1:0]  val [0:2];
      idx = '{CSR_WASH_PASSES, CSR_LEFT_DUTY, CSR_RIGHT_DUTY};
      val = '{passes, left, right};
      for (int i = 0; i < 3; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // stop offering and let every awaited result come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("washer_step_sequencer_unit_test: done, errors");
         $finish;
      end
   end

   // receiver: random ready stretches, one long hold-off on request
   initial begin : receiver
      int len;
      logic rdy;
      while (reset) @(posedge clock);
      forever begin
         if (hold_due) begin
            hold_due = 1'b0;
            rdy      = 1'b0;
            len      = LONG_HOLD;
         end else if (rx_calm) begin
            rdy = 1'b1;
            len = 1;
         end else if ($urandom_range(0, 2) == 0) begin
            rdy = 1'b0;
            len = gap_len();
         end else begin
            rdy = 1'b1;
            len = $urandom_range(1, 8);
         end
         rsp_tready <= rdy;
         repeat (len) @(posedge clock);
      end
   end

   // stimulus
   initial begin : stimulus
      logic [5:0] lv;
      int         gap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_beats[i]) send_beat(opening_beats[i], 0);
      drain_results();
      load_settings(7'd0, 7'd127, 7'd0);
      foreach (full_wash_beats[i]) send_beat(full_wash_beats[i], 0);
      drain_results();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // small pass counts reach spin and done; two phases take the large ones
         load_settings((p == 5) ? 7'd99 : (p == 9) ? 7'd127 : 7'($urandom_range(0, 4)),
                       duty_pick(p), duty_pick(p + 2));
         tx_calm = (p == 2 || p == 6);
         rx_calm = (p == 6);
         // sender keeps offering while the receiver holds off, so the block backs up
         if (p == 2) hold_due = 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               lv = 6'($urandom);   // noise
            end else begin
               // well-formed bias: sensors and ticks often, stop rarely
               lv = '0;
               if ($urandom_range(0, 99) < 35) lv |= LV_START;
               if ($urandom_range(0, 99) < 3)  lv |= LV_STOP;
               if ($urandom_range(0, 99) < 35) lv |= LV_FULL;
               if ($urandom_range(0, 99) < 35) lv |= LV_HOT;
               if ($urandom_range(0, 99) < 20) lv |= LV_EMPTY;
               if ($urandom_range(0, 99) < 60) lv |= LV_TICK;
            end
            gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
            send_beat(lv, gap);
         end
         drain_results();
      end

      if (fail_count == 0) begin
         $display("washer_step_sequencer_unit_test: done, clean");
      end else begin
         $display("washer_step_sequencer_unit_test: done, errors");
      end
      $finish;
   end

endmodule
